// File: src/tsdf_pkg.sv
// ----------------------------------------------------------------------------
// tsdf_pkg
// Shared types and constants for the voxel fusion block: item and result
// layouts, the stored voxel entry, the queue command and the back-end states.
// ----------------------------------------------------------------------------
package tsdf_pkg;

    // Grid geometry: one 6-bit index per axis, 64 voxels along each axis.
    localparam int IDX_W    = 6;
    localparam int GRID_DIM = 64;
    localparam int ADDR_W   = 3 * IDX_W;

    // Division datapath widths.
    localparam int NUM_W = 34;   // magnitude of a weighted sum
    localparam int DEN_W = 17;   // old weight plus new weight
    localparam int QUO_W = 17;   // quotient magnitude

    // Item kinds.
    localparam logic KIND_FUSE   = 1'b0;
    localparam logic KIND_COLOUR = 1'b1;

    // Averaging channels handled by the shared divider.
    localparam logic [1:0] CH_SDF   = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_GREEN = 2'd2;
    localparam logic [1:0] CH_BLUE  = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  index_x;
        logic [IDX_W-1:0]  index_y;
        logic [IDX_W-1:0]  index_z;
        logic signed [15:0] sdf_in;
        logic [15:0]       weight_in;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
    } item_t;

    typedef struct packed {
        logic              applied;
        logic signed [15:0] sdf_out;
        logic [15:0]       weight_out;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
    } result_t;

    // Stored voxel: distance in the low bits, blue in the high bits.
    typedef struct packed {
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic [15:0]       weight;
        logic signed [15:0] sdf;
    } voxel_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic  ok;
        item_t item;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

// File: src/tsdf_voxel_fusion_top.sv
// ----------------------------------------------------------------------------
// tsdf_voxel_fusion_top
// Fuses observations into a 64x64x64 truncated signed distance voxel grid.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on s_valid/s_ready/s_item. Each item yields exactly one
// result on m_valid/m_ready/m_result with the voxel contents after the step,
// or an all-zero result with applied low when the item is ignored.
// The weight clamp is written through cfg_valid/cfg_ready/cfg_data, which is
// always ready; write it only while no item is in flight.
// After reset the grid is cleared in a pass over all 262144 voxels, one voxel per
// cycle; s_ready stays low during that pass.
// Ignored and set-colour items do not use the divider; a fuse item uses the shared
// one-bit-per-cycle divider, which runs four 17-step divisions (distance and three
// colours) in turn.
// Items are handled one at a time; a two-entry queue keeps accepting while the
// back end works, and a result register holds the result while the receiver
// stalls, so the next item can proceed until it needs that register.
// ----------------------------------------------------------------------------
module tsdf_voxel_fusion_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tsdf_pkg::item_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output tsdf_pkg::result_t m_result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    logic           cfg_write;
    logic [15:0]    wmax_reg, wmax_next;
    logic           clear_busy;
    logic           q_full, q_empty, q_push, q_pop;
    tsdf_pkg::cmd_t q_cmd, q_head;

    // Weight clamp register.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign wmax_next = cfg_write ? cfg_data : wmax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wmax_reg <= 16'hFFFF;
        end else begin
            wmax_reg <= wmax_next;
        end
    end

    tsdf_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    tsdf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tsdf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .weight_max (wmax_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

endmodule

// File: src/tsdf_front.sv
// ----------------------------------------------------------------------------
// tsdf_front
// Accepts input items and classifies them as applicable or ignored.
// ----------------------------------------------------------------------------
module tsdf_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  tsdf_pkg::item_t s_item,
    input  logic            clear_busy,
    input  logic            q_full,
    output logic            q_push,
    output tsdf_pkg::cmd_t  q_cmd
);

    logic idx_ok;
    logic wgt_ok;

    // An item is taken when the queue has room and the grid is not being cleared.
    assign s_ready = !q_full && !clear_busy;
    assign q_push  = s_valid && s_ready;

    // Any zero index, or a fuse with zero weight, makes the item a no-op.
    assign idx_ok = (s_item.index_x != '0) && (s_item.index_y != '0) &&
                    (s_item.index_z != '0);
    assign wgt_ok = (s_item.kind == tsdf_pkg::KIND_COLOUR) || (s_item.weight_in != '0);

    assign q_cmd.ok   = idx_ok && wgt_ok;
    assign q_cmd.item = s_item;

endmodule

// File: src/tsdf_queue.sv
// ----------------------------------------------------------------------------
// tsdf_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tsdf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tsdf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output tsdf_pkg::cmd_t head_cmd,
    output logic           full,
    output logic           empty
);

    tsdf_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/tsdf_div.sv
// ----------------------------------------------------------------------------
// tsdf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsdf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tsdf_pkg::NUM_W-1:0]  num,
    input  logic [tsdf_pkg::DEN_W-1:0]  den,
    output logic                        done,
    output logic [tsdf_pkg::QUO_W-1:0]  quot
);

    localparam int CNT_W = $clog2(tsdf_pkg::QUO_W + 1);

    logic [tsdf_pkg::DEN_W-1:0] rem_reg,  rem_next;
    logic [tsdf_pkg::QUO_W-1:0] sh_reg,   sh_next;
    logic [tsdf_pkg::QUO_W-1:0] quot_reg, quot_next;
    logic [tsdf_pkg::DEN_W-1:0] den_reg,  den_next;
    logic [CNT_W-1:0]           cnt_reg,  cnt_next;
    logic                       done_reg, done_next;
    logic [tsdf_pkg::DEN_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, sh_reg[tsdf_pkg::QUO_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // The quotient fits in QUO_W bits, so the upper numerator bits start
    // the remainder and only QUO_W steps remain.
    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num[tsdf_pkg::NUM_W-1:tsdf_pkg::QUO_W];
            sh_next   = num[tsdf_pkg::QUO_W-1:0];
            den_next  = den;
            quot_next = '0;
            cnt_next  = CNT_W'(tsdf_pkg::QUO_W);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? tsdf_pkg::DEN_W'(trial - {1'b0, den_reg})
                             : trial[tsdf_pkg::DEN_W-1:0];
            sh_next   = {sh_reg[tsdf_pkg::QUO_W-2:0], 1'b0};
            quot_next = {quot_reg[tsdf_pkg::QUO_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: src/tsdf_back.sv
// ----------------------------------------------------------------------------
// tsdf_back
// Voxel memory, clearing pass, averaging sequencer and result register.
// ----------------------------------------------------------------------------
module tsdf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       weight_max,
    input  logic              q_empty,
    input  tsdf_pkg::cmd_t    q_head,
    output logic              q_pop,
    output logic              clear_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output tsdf_pkg::result_t m_result
);

    localparam int DEPTH = tsdf_pkg::GRID_DIM * tsdf_pkg::GRID_DIM * tsdf_pkg::GRID_DIM;

    tsdf_pkg::voxel_t            mem [DEPTH];
    tsdf_pkg::back_state_t       state_reg, state_next;
    logic [tsdf_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    tsdf_pkg::cmd_t              cmd_reg;
    tsdf_pkg::voxel_t            rd_data_reg;
    logic [1:0]                  chan_reg, chan_next;
    logic [tsdf_pkg::NUM_W-1:0]  num_mag_reg;
    logic                        neg_reg;
    logic [tsdf_pkg::DEN_W-1:0]  den_reg;
    logic [tsdf_pkg::QUO_W-1:0]  q_sdf_reg;
    logic [7:0]                  q_red_reg, q_green_reg, q_blue_reg;
    logic                        out_valid_reg, out_valid_next;
    tsdf_pkg::result_t           out_reg;

    logic                        rd_en, wr_en, div_start, load_out, take_cmd;
    logic [tsdf_pkg::ADDR_W-1:0] addr;
    tsdf_pkg::voxel_t            wr_data, new_vox;
    logic signed [16:0]          op_old, op_new;
    logic signed [33:0]          prod_old, prod_new;
    logic signed [34:0]          wsum;
    logic [tsdf_pkg::NUM_W-1:0]  wsum_mag;
    logic                        div_done;
    logic [tsdf_pkg::QUO_W-1:0]  div_quot;
    logic [tsdf_pkg::QUO_W-1:0]  sdf_q;
    logic [16:0]                 w_sum;
    logic [15:0]                 w_new;
    logic                        out_free;

    assign addr     = {cmd_reg.item.index_x, cmd_reg.item.index_y, cmd_reg.item.index_z};
    assign out_free = !out_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tsdf_pkg::ST_CLEAR: begin
                if (clr_addr_reg == '1) state_next = tsdf_pkg::ST_IDLE;
            end
            tsdf_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    state_next = q_head.ok ? tsdf_pkg::ST_READ : tsdf_pkg::ST_DONE;
                end
            end
            tsdf_pkg::ST_READ: state_next = tsdf_pkg::ST_LOAD;
            tsdf_pkg::ST_LOAD: begin
                state_next = (cmd_reg.item.kind == tsdf_pkg::KIND_FUSE) ?
                             tsdf_pkg::ST_MUL : tsdf_pkg::ST_DONE;
            end
            tsdf_pkg::ST_MUL:    state_next = tsdf_pkg::ST_DIV_GO;
            tsdf_pkg::ST_DIV_GO: state_next = tsdf_pkg::ST_DIV;
            tsdf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = (chan_reg == tsdf_pkg::CH_BLUE) ?
                                 tsdf_pkg::ST_DONE : tsdf_pkg::ST_MUL;
                end
            end
            tsdf_pkg::ST_DONE: begin
                if (out_free) state_next = tsdf_pkg::ST_IDLE;
            end
            default: state_next = tsdf_pkg::ST_CLEAR;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        take_cmd   = 1'b0;
        clear_busy = 1'b0;
        case (state_reg)
            tsdf_pkg::ST_CLEAR: begin
                clear_busy = 1'b1;
                wr_en      = 1'b1;
            end
            tsdf_pkg::ST_IDLE:   take_cmd  = !q_empty;
            tsdf_pkg::ST_READ:   rd_en     = 1'b1;
            tsdf_pkg::ST_DIV_GO: div_start = 1'b1;
            tsdf_pkg::ST_DONE: begin
                load_out = out_free;
                wr_en    = out_free && cmd_reg.ok;
            end
            default: begin
            end
        endcase
    end

    assign q_pop = take_cmd;

    // Channel counter for the four averages.
    always_comb begin
        chan_next = chan_reg;
        if (state_reg == tsdf_pkg::ST_LOAD) begin
            chan_next = tsdf_pkg::CH_SDF;
        end else if (state_reg == tsdf_pkg::ST_DIV && div_done) begin
            chan_next = chan_reg + 2'd1;
        end
        clr_addr_next = (state_reg == tsdf_pkg::ST_CLEAR) ? clr_addr_reg + 1'b1 : clr_addr_reg;
    end

    // Weighted sum for the current channel: old_w * old + w * obs.
    always_comb begin
        case (chan_reg)
            tsdf_pkg::CH_SDF: begin
                op_old = 17'(rd_data_reg.sdf);
                op_new = 17'(cmd_reg.item.sdf_in);
            end
            tsdf_pkg::CH_RED: begin
                op_old = {9'd0, rd_data_reg.red};
                op_new = {9'd0, cmd_reg.item.red_in};
            end
            tsdf_pkg::CH_GREEN: begin
                op_old = {9'd0, rd_data_reg.green};
                op_new = {9'd0, cmd_reg.item.green_in};
            end
            default: begin
                op_old = {9'd0, rd_data_reg.blue};
                op_new = {9'd0, cmd_reg.item.blue_in};
            end
        endcase
        prod_old = $signed({1'b0, rd_data_reg.weight}) * op_old;
        prod_new = $signed({1'b0, cmd_reg.item.weight_in}) * op_new;
        wsum     = 35'(prod_old) + 35'(prod_new);
        wsum_mag = wsum[34] ? tsdf_pkg::NUM_W'(-wsum) : tsdf_pkg::NUM_W'(wsum);
    end

    tsdf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_mag_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Updated voxel contents.
    always_comb begin
        w_sum   = {1'b0, rd_data_reg.weight} + {1'b0, cmd_reg.item.weight_in};
        w_new   = (w_sum > {1'b0, weight_max}) ? weight_max : w_sum[15:0];
        sdf_q   = neg_reg ? tsdf_pkg::QUO_W'(-q_sdf_reg) : q_sdf_reg;
        new_vox = rd_data_reg;
        if (cmd_reg.item.kind == tsdf_pkg::KIND_FUSE) begin
            new_vox.sdf    = sdf_q[15:0];
            new_vox.weight = w_new;
            new_vox.red    = q_red_reg;
            new_vox.green  = q_green_reg;
            new_vox.blue   = q_blue_reg;
        end else begin
            new_vox.red    = cmd_reg.item.red_in;
            new_vox.green  = cmd_reg.item.green_in;
            new_vox.blue   = cmd_reg.item.blue_in;
        end
        wr_data = (state_reg == tsdf_pkg::ST_CLEAR) ? '0 : new_vox;
    end

    // Output valid flag.
    always_comb begin
        if (load_out) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tsdf_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            chan_reg      <= tsdf_pkg::CH_SDF;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Voxel memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[(state_reg == tsdf_pkg::ST_CLEAR) ? clr_addr_reg : addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (take_cmd) begin
            cmd_reg <= q_head;
        end
        if (state_reg == tsdf_pkg::ST_MUL) begin
            num_mag_reg <= wsum_mag;
            neg_reg     <= (chan_reg == tsdf_pkg::CH_SDF) ? wsum[34] : neg_reg;
            den_reg     <= w_sum;
        end
        if (state_reg == tsdf_pkg::ST_DIV && div_done) begin
            case (chan_reg)
                tsdf_pkg::CH_SDF:   q_sdf_reg   <= div_quot;
                tsdf_pkg::CH_RED:   q_red_reg   <= div_quot[7:0];
                tsdf_pkg::CH_GREEN: q_green_reg <= div_quot[7:0];
                default:            q_blue_reg  <= div_quot[7:0];
            endcase
        end
        if (load_out) begin
            if (cmd_reg.ok) begin
                out_reg.applied    <= 1'b1;
                out_reg.sdf_out    <= new_vox.sdf;
                out_reg.weight_out <= new_vox.weight;
                out_reg.red_out    <= new_vox.red;
                out_reg.green_out  <= new_vox.green;
                out_reg.blue_out   <= new_vox.blue;
            end else begin
                out_reg <= '0;
            end
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

// File: src/tsdf_checker.sv
// ----------------------------------------------------------------------------
// tsdf_checker
// Port-level checks on the result channel and on reset of the voxel fusion block.
// ----------------------------------------------------------------------------
module tsdf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input tsdf_pkg::result_t m_result
);

    // A stalled result item stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    // A stalled result item keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result))
        else $error("result changed while stalled");

    // An ignored item reports an all-zero voxel.
    a_ignored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.applied |->
            m_result.sdf_out == '0 && m_result.weight_out == '0 &&
            m_result.red_out == '0 && m_result.green_out == '0 &&
            m_result.blue_out == '0)
        else $error("ignored item carries nonzero fields");

    // Reset leaves no result pending and starts the clearing pass.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block not idle after reset");

endmodule

bind tsdf_voxel_fusion_top tsdf_checker u_tsdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
